FILE: src/iac_pkg.sv
// Shared types, constants and tables of the IMA ADPCM codec.
package iac_pkg;

  localparam int unsigned STEP_COUNT = 89;
  localparam logic [6:0] IDX_MAX = 7'd88;
  localparam logic [7:0] PCM8_FLIP = 8'h80;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } phase_t;

  typedef enum logic {
    REG_ENCODE_MODE   = 1'b0,
    REG_EIGHT_BIT_PCM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic encode_mode;
    logic eight_bit_pcm;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic               eight_bit;
    logic               channel;
    logic               restart;
    logic [7:0]         code_byte;
    logic signed [15:0] sample;
  } item_t;

  localparam logic [14:0] STEP_TABLE [STEP_COUNT] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // index adjustment of the low three code bits: -1 or 2, 4, 6, 8
  function automatic logic signed [4:0] index_adjust(input logic [2:0] c);
    logic signed [4:0] adj;
    if (c[2]) begin
      adj = $signed({2'b00, c[1:0], 1'b0}) + 5'sd2;
    end else begin
      adj = -5'sd1;
    end
    return adj;
  endfunction

endpackage

FILE: src/iac_front.sv
// Input side: accepts items, classifies them by mode and queues them for the engine.
module iac_front (
  input  logic                clk,
  input  logic                rst_n,
  input  iac_pkg::cfg_t       cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tuser,
  output logic                q_valid,
  output iac_pkg::item_t      q_item,
  input  logic                q_pop
);

  iac_pkg::item_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  iac_pkg::item_t item_new;
  logic [15:0]    pcm_raw;

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];
  assign pcm_raw   = in_tdata[23:8];

  always_comb begin
    item_new.op        = cfg.encode_mode ? iac_pkg::OP_ENCODE : iac_pkg::OP_DECODE;
    item_new.eight_bit = cfg.eight_bit_pcm;
    item_new.channel   = in_tuser;
    item_new.restart   = in_tdata[24];
    item_new.code_byte = in_tdata[7:0];
    // 8-bit PCM is unsigned: move to the high byte and flip the sign bit
    if (cfg.eight_bit_pcm) begin
      item_new.sample = $signed({pcm_raw[7:0] ^ iac_pkg::PCM8_FLIP, 8'h00});
    end else begin
      item_new.sample = $signed(pcm_raw);
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_new;
    end
  end

endmodule

FILE: src/iac_back.sv
// Engine: per-channel ADPCM state, shared nibble update unit and output register.
module iac_back #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  iac_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic signed [15:0] pred_r [NUM_CHANNELS];
  logic [6:0]         idx_r  [NUM_CHANNELS];
  logic [3:0]         pend_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] par_r;

  iac_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      code_r;

  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_pcm_r;
  logic [7:0]         out_code_r;
  logic               out_chan_r;
  logic               out_last_r;

  logic               ch_bit;
  logic [CH_W-1:0]    ch;
  logic               is_enc;
  logic               second;
  logic               emit;
  logic               out_free;
  logic               go;
  logic               apply;
  logic [3:0]         nib;

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] pred_new;
  logic signed [8:0]  ni;
  logic [6:0]         idx_new;
  logic [15:0]        pcm_val;

  logic signed [16:0] delta;
  logic [16:0]        rem;
  logic [16:0]        trial;
  logic [3:0]         enc_code;

  assign ch_bit = (32'(q_item.channel) < NUM_CHANNELS) ? q_item.channel : 1'b0;
  assign ch     = CH_W'(ch_bit);
  assign is_enc = (q_item.op == iac_pkg::OP_ENCODE);
  assign second = (phase_r == iac_pkg::PH_SECOND);

  assign emit     = !is_enc || (second && par_r[ch]);
  assign out_free = !out_valid_r || out_tready;
  assign go       = q_valid && (!emit || out_free);
  assign q_pop    = go && second;
  assign apply    = !is_enc || second;

  always_comb begin
    if (is_enc) begin
      nib = code_r;
    end else if (second) begin
      nib = q_item.code_byte[7:4];
    end else begin
      nib = q_item.code_byte[3:0];
    end
  end

  // nibble update: difference from step shifts, clamped predictor and index
  always_comb begin
    idx_c = (idx_r[ch] > iac_pkg::IDX_MAX) ? iac_pkg::IDX_MAX : idx_r[ch];
    step  = iac_pkg::STEP_TABLE[idx_c];
    diff  = 17'(step >> 3);
    if (nib[2]) diff = diff + 17'(step);
    if (nib[1]) diff = diff + 17'(step >> 1);
    if (nib[0]) diff = diff + 17'(step >> 2);
    if (nib[3]) begin
      sum = 18'(pred_r[ch]) - $signed({1'b0, diff});
    end else begin
      sum = 18'(pred_r[ch]) + $signed({1'b0, diff});
    end
    if (sum < -18'sd32768) begin
      pred_new = -16'sd32768;
    end else if (sum > 18'sd32767) begin
      pred_new = 16'sd32767;
    end else begin
      pred_new = sum[15:0];
    end
    ni = $signed({2'b00, idx_c}) + 9'(iac_pkg::index_adjust(nib[2:0]));
    if (ni < 9'sd0) begin
      idx_new = 7'd0;
    end else if (ni > $signed({2'b00, iac_pkg::IDX_MAX})) begin
      idx_new = iac_pkg::IDX_MAX;
    end else begin
      idx_new = ni[6:0];
    end
    if (q_item.eight_bit) begin
      pcm_val = {8'h00, pred_new[15:8] ^ iac_pkg::PCM8_FLIP};
    end else begin
      pcm_val = pred_new;
    end
  end

  // encoder successive approximation against step, step/2, step/4
  always_comb begin
    delta       = 17'(q_item.sample) - 17'(pred_r[ch]);
    enc_code    = {delta[16], 3'b000};
    rem         = delta[16] ? 17'(-delta) : 17'(delta);
    trial       = 17'(step);
    for (int k = 0; k < 3; k++) begin
      if (rem >= trial) begin
        enc_code[2-k] = 1'b1;
        rem           = rem - trial;
      end
      trial = trial >> 1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      iac_pkg::PH_FIRST:  if (go) phase_nxt = iac_pkg::PH_SECOND;
      iac_pkg::PH_SECOND: if (go) phase_nxt = iac_pkg::PH_FIRST;
      default:            phase_nxt = iac_pkg::PH_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= iac_pkg::PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pred_r[i] <= '0;
        idx_r[i]  <= '0;
        pend_r[i] <= '0;
        par_r[i]  <= 1'b0;
      end
    end else if (go) begin
      if (apply) begin
        pred_r[ch] <= pred_new;
        idx_r[ch]  <= idx_new;
      end
      if (!second && q_item.restart) begin
        par_r <= '0;
      end
      if (second && is_enc) begin
        par_r[ch] <= !par_r[ch];
        if (!par_r[ch]) begin
          pend_r[ch] <= code_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !second && is_enc) begin
      code_r <= enc_code;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_chan_r <= ch_bit;
      out_last_r <= is_enc || second;
      if (is_enc) begin
        out_pcm_r  <= '0;
        out_code_r <= {code_r, pend_r[ch]};
      end else begin
        out_pcm_r  <= pcm_val;
        out_code_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_code_r, out_pcm_r};
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (idx_r[ch] <= iac_pkg::IDX_MAX))
    else $error("step index above table");

  a_second_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == iac_pkg::PH_SECOND) |-> q_valid)
    else $error("second phase without a queued item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit) |-> out_free)
    else $error("result written over a waiting one");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit && second) |=> (out_valid_r && out_last_r))
    else $error("final result of an item not marked last");
`endif

endmodule

FILE: src/ima_adpcm_codec.sv
// Four-bit IMA ADPCM codec, top level: configuration registers, front queue and engine.
//
// Every item, a code byte to decode or a PCM sample to encode, goes through the engine's
// first and second phases and leaves the queue on the second; a phase that emits a
// result waits for a free output register. A decoded byte gives two samples, low nibble
// first, the second marked by tlast; an encoded sample gives no result on the first of
// a pair per channel and the packed byte on the second. The two-phase sequence runs
// around a single shared nibble update unit (two chained updates per decoded byte;
// approximation then update per sample). A two-item queue decouples input from the
// engine and a result register decouples the output, so input items are taken while a
// result waits. The user writes configuration only while the block is idle; the block itself does not enforce this.
module ima_adpcm_codec #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // code_byte[7:0], pcm_sample[23:8], restart[24], zero
  input  logic        in_tuser,   // channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pcm_out[15:0], packed_code[23:16]
  output logic        out_tuser,  // out_channel
  output logic        out_tlast
);

  iac_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           q_valid;
  iac_pkg::item_t q_item;
  logic           q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (iac_pkg::reg_idx_t'(cfg_index))
        iac_pkg::REG_ENCODE_MODE:   cfg_nxt.encode_mode   = cfg_wdata;
        iac_pkg::REG_EIGHT_BIT_PCM: cfg_nxt.eight_bit_pcm = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  iac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  iac_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: bench/tb_top.sv
// Stream-level testbench for the IMA ADPCM codec: random stimulus, a model of its own, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE      = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 178;

  typedef struct packed {
    logic        ch;
    logic [7:0]  code;
    logic [15:0] sample;
    logic        restart;
  } stim_t;

  typedef struct packed {
    logic        ch;
    logic [15:0] pcm;
    logic [7:0]  code;
    logic        last;
  } codec_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // code_byte[7:0], pcm_sample[23:8], restart[24], zero
  logic        in_tuser = 1'b0; // channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // pcm_out[15:0], packed_code[23:16]
  logic        out_tuser;       // out_channel
  logic        out_tlast;

  ima_adpcm_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // codec state of our own
  iac_pkg::op_t cfg_op = iac_pkg::OP_DECODE;
  logic cfg_eight = 1'b0;
  int   chan_pred [2] = '{default: 0};
  int   chan_idx [2] = '{default: 0};
  logic [3:0] chan_pend [2] = '{default: '0};
  logic chan_par [2] = '{default: 1'b0};

  stim_t      pending_items [$];
  codec_out_t due_outputs [$];
  stim_t      offered;
  codec_out_t want;
  int n_queued = 0;
  int n_accepted = 0;
  int err_count = 0;
  int quiet_cycles = 0;
  int walk [2] = '{default: 0};

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   in_gap_left = 0;
  int   out_wait_left = 0;
  int   hold_left = 0;
  logic hold_off_req = 1'b0;
  logic in_calm = 1'b0;
  logic out_calm = 1'b0;

  function automatic int apply_code(input int ch, input logic [3:0] nib);
    int step, diff, sum, ni;
    step = int'(iac_pkg::STEP_TABLE[chan_idx[ch]]);
    diff = step >>> 3;
    if (nib[2]) diff += step;
    if (nib[1]) diff += step >>> 1;
    if (nib[0]) diff += step >>> 2;
    if (nib[3]) diff = -diff;
    sum = chan_pred[ch] + diff;
    if (sum < -32768) sum = -32768;
    if (sum > 32767) sum = 32767;
    chan_pred[ch] = sum;
    ni = chan_idx[ch] + (nib[2] ? 2 * (int'(nib[1:0]) + 1) : -1);
    if (ni < 0) ni = 0;
    if (ni > int'(iac_pkg::IDX_MAX)) ni = int'(iac_pkg::IDX_MAX);
    chan_idx[ch] = ni;
    return sum;
  endfunction

  function automatic logic [15:0] pcm_view(input int s);
    logic [15:0] u;
    u = 16'(s);
    if (cfg_eight) return {8'h00, u[15:8] ^ iac_pkg::PCM8_FLIP};
    return u;
  endfunction

  function automatic void codec_step(input stim_t it);
    int ch, cur, delta, step, s;
    logic [15:0] raw;
    logic [3:0] code;
    codec_out_t r;
    ch = int'(it.ch);
    if (it.restart) begin
      chan_par[0] = 1'b0;
      chan_par[1] = 1'b0;
    end
    r.ch = it.ch;
    if (cfg_op == iac_pkg::OP_DECODE) begin
      s = apply_code(ch, it.code[3:0]);
      r.pcm = pcm_view(s);
      r.code = 8'h00;
      r.last = 1'b0;
      due_outputs.push_back(r);
      s = apply_code(ch, it.code[7:4]);
      r.pcm = pcm_view(s);
      r.last = 1'b1;
      due_outputs.push_back(r);
    end else begin
      raw = it.sample;
      if (cfg_eight) raw = {it.sample[7:0], 8'h00} ^ 16'h8000;
      cur = int'($signed(raw));
      step = int'(iac_pkg::STEP_TABLE[chan_idx[ch]]);
      delta = cur - chan_pred[ch];
      code = 4'h0;
      if (delta < 0) begin
        delta = -delta;
        code[3] = 1'b1;
      end
      for (int b = 2; b >= 0; b--) begin
        if (delta >= step) begin
          code[b] = 1'b1;
          delta -= step;
        end
        step = step >>> 1;
      end
      void'(apply_code(ch, code));
      if (chan_par[ch]) begin
        chan_par[ch] = 1'b0;
        r.pcm = 16'h0000;
        r.code = {code, chan_pend[ch]};
        r.last = 1'b1;
        due_outputs.push_back(r);
      end else begin
        chan_pend[ch] = code;
        chan_par[ch] = 1'b1;
      end
    end
  endfunction

  task automatic log_error(input string what, input int got, input int exp_val);
    err_count++;
    $display("ERROR at %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, exp_val);
  endtask

  function automatic int draw_in_gap();
    if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
    return in_calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic int draw_out_wait();
    if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
    return out_calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_fire) in_gap_left = draw_in_gap();
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        offered = pending_items.pop_front();
        in_tdata <= {7'b0, offered.restart, offered.sample, offered.code};
        in_tuser <= offered.ch;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      codec_step(offered);
      n_accepted++;
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_off_req) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (out_fire) out_wait_left = draw_out_wait();
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_wait_left > 0) begin
        out_wait_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_fire <= 1'b1;
      if (due_outputs.size() == 0) begin
        log_error("result with nothing due, tdata", int'(out_tdata), 0);
      end else begin
        want = due_outputs.pop_front();
        if (out_tuser !== want.ch) log_error("out_channel", int'(out_tuser), int'(want.ch));
        if (out_tdata[15:0] !== want.pcm)
          log_error("pcm_out", int'(out_tdata[15:0]), int'(want.pcm));
        if (out_tdata[23:16] !== want.code)
          log_error("packed_code", int'(out_tdata[23:16]), int'(want.code));
        if (out_tlast !== want.last) log_error("last", int'(out_tlast), int'(want.last));
      end
    end else begin
      out_fire <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_item(input logic ch, input logic [7:0] code, input logic [15:0] sample,
                           input logic restart);
    stim_t it;
    it.ch = ch;
    it.code = code;
    it.sample = sample;
    it.restart = restart;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // called at a falling edge with the block idle
  task automatic set_config(input iac_pkg::op_t op, input logic eight);
    cfg_we <= 1'b1;
    cfg_index <= iac_pkg::REG_ENCODE_MODE;
    cfg_wdata <= op;
    @(negedge clk);
    cfg_index <= iac_pkg::REG_EIGHT_BIT_PCM;
    cfg_wdata <= eight;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_op = op;
    cfg_eight = eight;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || due_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic add_random(input int n);
    stim_t it;
    int r, span;
    logic [15:0] w;
    for (int k = 0; k < n; k++) begin
      it.ch = 1'($urandom_range(0, 1));
      it.restart = ($urandom_range(0, 15) == 0);
      it.code = 8'($urandom);
      it.sample = 16'($urandom);
      r = $urandom_range(0, 15);
      if (cfg_op == iac_pkg::OP_DECODE) begin
        if (r < 2) it.code = 8'h77;
        else if (r < 4) it.code = 8'hFF;
        else if (r == 4) it.code = 8'h00;
      end else if (r == 1) begin
        it.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end else if (r >= 2) begin
        span = (r == 2) ? 30000 : 2000;
        walk[it.ch] += int'($urandom_range(0, 2 * span)) - span;
        if (walk[it.ch] > 32767) walk[it.ch] = 32767;
        if (walk[it.ch] < -32768) walk[it.ch] = -32768;
        w = 16'(walk[it.ch]);
        if (cfg_eight) it.sample[7:0] = w[15:8] ^ iac_pkg::PCM8_FLIP;
        else it.sample = w;
      end
      push_item(it.ch, it.code, it.sample, it.restart);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // decode, 16-bit: index floor, climb to the top index with the predictor clamped high,
    // then clamp low; negative zero-magnitude code; restart on a decode item
    set_config(iac_pkg::OP_DECODE, 1'b0);
    push_item(1'b0, 8'h00, 16'h0000, 1'b0);
    for (int k = 0; k < 6; k++) push_item(1'b0, 8'h77, 16'hFFFF, 1'b0);
    for (int k = 0; k < 4; k++) push_item(1'b0, 8'hFF, 16'h0000, 1'b0);
    push_item(1'b1, 8'h08, 16'h7FFF, 1'b0);
    push_item(1'b1, 8'h80, 16'h8000, 1'b1);
    push_item(1'b1, 8'h31, 16'h0001, 1'b0);
    wait_idle();

    // encode, 16-bit: full-scale swings, restart dropping a half-built byte
    set_config(iac_pkg::OP_ENCODE, 1'b0);
    push_item(1'b0, 8'hFF, 16'h7FFF, 1'b0);
    push_item(1'b0, 8'h00, 16'h8000, 1'b0);
    push_item(1'b1, 8'h5A, 16'h0000, 1'b0);
    push_item(1'b1, 8'hA5, 16'h7FFF, 1'b1);
    push_item(1'b1, 8'h00, 16'h8000, 1'b0);
    wait_idle();

    set_config(iac_pkg::OP_ENCODE, 1'b1);
    push_item(1'b0, 8'h00, 16'hFF00, 1'b0);
    push_item(1'b0, 8'hFF, 16'h00FF, 1'b0);
    wait_idle();

    set_config(iac_pkg::OP_DECODE, 1'b1);
    push_item(1'b0, 8'h77, 16'h1234, 1'b0);
    push_item(1'b1, 8'hF8, 16'hEDCB, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      set_config(p[0] ? iac_pkg::OP_ENCODE : iac_pkg::OP_DECODE, p[1]);
      if (p == 2) hold_off_req = 1'b1;
      add_random(PHASE_ITEMS);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: ima_adpcm_codec.f
src/iac_pkg.sv
src/iac_front.sv
src/iac_back.sv
src/ima_adpcm_codec.sv
bench/tb_top.sv
